>>> sv/ssc_pkg.sv
// Shared types, widths and phase tables for the six-step commutation angle core.
// No dependencies; imported by ssc_div, ssc_mul, the core, the checker and the testbench.
package ssc_pkg;

	localparam int FULL_ANGLE_DEF = 360000;
	localparam int MIN_FULL       = 6;

	// Serial divider: left-aligned dividend, quotient shifts in from the bottom
	localparam int DVD_W = 34;
	localparam int DSR_W = 19;
	localparam int CNT_W = 6;

	// Serial multiplier: 17 x 16 bits, one multiplier bit per cycle
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int MCNT_W  = 4;

	// Dividend lengths, in bits, of each division
	localparam int SUM_MAG_W = 20;
	localparam int FOLD_W    = DSR_W;
	localparam int PT_DVD_W  = PROD_W;
	localparam int HT_DVD_W  = 23;
	localparam int STEP_W    = 25;

	localparam int POS_W = 18;
	localparam int ZP_W  = 17;

	localparam logic [DSR_W-1:0] PERCENT_DIV = 19'd100;

	// Command op codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_VELOCITY      = 3'd0;
	localparam logic [2:0] REG_POLE_COUNT    = 3'd1;
	localparam logic [2:0] REG_DRIVE_ENABLE  = 3'd2;
	localparam logic [2:0] REG_POWER_PERCENT = 3'd3;
	localparam logic [2:0] REG_PWM_PERIOD    = 3'd4;

	typedef struct packed {
		logic               op;
		logic signed [15:0] angle_step;
	} cmd_t;

	typedef struct packed {
		logic               drive_on;
		logic [2:0]         zone;
		logic [1:0]         high_phase;
		logic [1:0]         low_phase;
		logic [1:0]         pwm_phase;
		logic [17:0]        sector_ramp;
		logic [15:0]        pwm_on;
		logic [15:0]        high_time;
		logic signed [19:0] rotor_pos;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

	function automatic logic [1:0] high_phase_of(input logic [2:0] z);
		logic [1:0] p;
		case (z)
			3'd0: p = 2'd0;
			3'd1: p = 2'd1;
			3'd2: p = 2'd1;
			3'd3: p = 2'd2;
			3'd4: p = 2'd2;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] low_phase_of(input logic [2:0] z);
		logic [1:0] p;
		case (z)
			3'd0: p = 2'd2;
			3'd1: p = 2'd2;
			3'd2: p = 2'd0;
			3'd3: p = 2'd0;
			3'd4: p = 2'd1;
			default: p = 2'd1;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] pwm_phase_of(input logic [2:0] z);
		logic [1:0] p;
		case (z)
			3'd0: p = 2'd1;
			3'd1: p = 2'd0;
			3'd2: p = 2'd2;
			3'd3: p = 2'd1;
			3'd4: p = 2'd0;
			default: p = 2'd2;
		endcase
		return p;
	endfunction

endpackage

>>> sv/ssc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ssc_pkg for widths and the request/response structs.
module ssc_div import ssc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic           take;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign take  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= req.steps - CNT_W'(1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[DVD_W-2:0], take};
				rem_q <= take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

>>> sv/ssc_mul.sv
// Shift-add serial multiplier, one multiplier bit per cycle, 17 x 16 bits.
// Depends on ssc_pkg for widths and the request/response structs.
module ssc_mul import ssc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [PROD_W-1:0]  prod_q;
	logic [MUL_A_W-1:0] a_q;
	logic [MCNT_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [MUL_A_W:0] partial;

	// upper half plus the multiplicand when the outgoing multiplier bit is set
	assign partial = {1'b0, prod_q[PROD_W-1:MUL_B_W]}
		+ (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			a_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				prod_q <= {{MUL_A_W{1'b0}}, req.b};
				a_q    <= req.a;
				cnt_q  <= MCNT_W'(MUL_B_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {partial, prod_q[MUL_B_W-1:1]};
				cnt_q  <= cnt_q - MCNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = prod_q;

endmodule

>>> sv/six_step_commutation_angle_core.sv
// Six-step commutation angle core: angle accumulator, sequencer and result register.
// Depends on ssc_pkg, ssc_div and ssc_mul.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): op 0 is a period tick, op 1 a manual
//   angle step. res channel (res_valid / res_stall / res) carries one result per tick;
//   a step gives no result. Registers are written through cfg_wen / cfg_index /
//   cfg_data, by the user only while the core is idle; the core does not enforce this.
//   One item is worked at a time; cmd_stall is high from the transfer until the
//   sequencer returns to idle. The work runs through one serial divider and one
//   serial multiplier, one bit per cycle, each operation with a launch and a hand-off:
//     enabled tick  : divides of 20, 20, 19, 33 and 23 bits and two 16-bit multiplies,
//                     then the result load; the next transfer comes once back in idle
//     disabled tick : all fields zero, angle held
//     step          : no result; one 25-bit divide, then the angle wrap
//   The result register frees the sequencer: it goes idle as soon as the result is
//   loaded, and waits only if a previous result is still held by res_stall.
//   Reset (arst_n low) clears the angle to zero, loads the register defaults and
//   empties the result register.
module six_step_commutation_angle_core import ssc_pkg::*; #(
	parameter int FULL_ANGLE = FULL_ANGLE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	localparam int FULL   = (FULL_ANGLE < MIN_FULL) ? MIN_FULL : FULL_ANGLE;
	localparam int SECTOR = FULL / 6;
	localparam logic [DSR_W-1:0]  FULL_D      = DSR_W'(FULL);
	localparam logic [DSR_W-1:0]  SECTOR_D    = DSR_W'(SECTOR);
	localparam logic [ZP_W-1:0]   HALF_SECTOR = ZP_W'(SECTOR / 2);
	localparam logic [FOLD_W-1:0] LAST_BASE   = FOLD_W'(5 * SECTOR);
	localparam logic [20:0]       FULL_21     = 21'(FULL);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MECH,
		ST_MODF,
		ST_ZONE,
		ST_PTMUL,
		ST_PTDIV,
		ST_HTMUL,
		ST_HTDIV,
		ST_STEP,
		ST_WRAP,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   launch_q;

	logic signed [17:0] velocity_q;
	logic [6:0]         pole_count_q;
	logic               drive_enable_q;
	logic [6:0]         power_percent_q;
	logic [15:0]        pwm_period_q;

	logic                drive_q;
	logic                step_neg_q;
	logic [15:0]         step_mag_q;
	logic signed [20:0]  sum_q;
	logic signed [19:0]  angle_q;
	logic [19:0]         mech_q;
	logic [FOLD_W-1:0]   afold_q;
	logic [2:0]          zone_q;
	logic [POS_W-1:0]    pos_q;
	logic [ZP_W-1:0]     zp_q;
	logic [PROD_W-1:0]   prod_q;
	logic [15:0]         pt_q;
	logic [15:0]         ht_q;
	logic signed [20:0]  t_q;
	res_t                res_q;
	logic                res_valid_q;

	div_req_t div_req_q;
	div_rsp_t div_rsp;
	mul_req_t mul_req_q;
	mul_rsp_t mul_rsp;

	ssc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	ssc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.rsp    (mul_rsp)
	);

	// ---- datapath helpers ----
	logic [15:0]          step_raw;
	logic [15:0]          step_abs;
	logic [20:0]          sum_u;
	logic [SUM_MAG_W-1:0] sum_mag;
	logic [6:0]           poles;
	logic [25:0]          step_x1000;
	logic [19:0]          quo20;
	logic [19:0]          mech_sat;
	logic [19:0]          rem20;
	logic                 zone_over;
	logic [ZP_W-1:0]      zp_half;
	logic [ZP_W-1:0]      zp_calc;
	logic [15:0]          quo_sat16;
	logic signed [20:0]   rem21;
	logic [20:0]          t_u;
	logic [20:0]          t_mag;
	logic [20:0]          t_red;
	logic [20:0]          t_neg;
	logic [19:0]          wrap_angle;
	logic                 div_launch;
	logic                 mul_launch;

	assign step_raw = cmd.angle_step;
	assign step_abs = step_raw[15] ? (~step_raw + 16'd1) : step_raw;

	assign sum_u   = sum_q;
	assign sum_mag = sum_u[20] ? SUM_MAG_W'(~sum_u + 21'd1) : sum_u[SUM_MAG_W-1:0];
	assign poles   = (pole_count_q == '0) ? 7'd1 : pole_count_q;

	// x*1000 as x*1024 - x*16 - x*8
	assign step_x1000 = {step_mag_q, 10'b0} - 26'({step_mag_q, 4'b0})
		- 26'({step_mag_q, 3'b0});

	assign quo20 = div_rsp.quotient[19:0];
	always_comb begin
		if (sum_u[20]) begin
			mech_sat = (quo20 > 20'd524288) ? 20'h80000 : (~quo20 + 20'd1);
		end else begin
			mech_sat = (quo20 > 20'd524287) ? 20'h7FFFF : quo20;
		end
	end

	assign rem20     = {1'b0, div_rsp.remainder};
	assign zone_over = div_rsp.quotient > DVD_W'(5);

	// position inside the sector halved; mirrored in odd sectors, floored at zero
	assign zp_half = pos_q[POS_W-1:1];
	always_comb begin
		if (zone_q[0]) begin
			zp_calc = (zp_half > HALF_SECTOR) ? '0 : (HALF_SECTOR - zp_half);
		end else begin
			zp_calc = zp_half;
		end
	end

	assign quo_sat16 = (div_rsp.quotient > DVD_W'(16'hFFFF)) ? 16'hFFFF
		: div_rsp.quotient[15:0];

	assign rem21 = {2'b00, div_rsp.remainder};

	// (angle + r) stays within two turns: one compare-subtract reduces it
	assign t_u        = t_q;
	assign t_mag      = t_u[20] ? (~t_u + 21'd1) : t_u;
	assign t_red      = (t_mag >= FULL_21) ? (t_mag - FULL_21) : t_mag;
	assign t_neg      = ~t_red + 21'd1;
	assign wrap_angle = t_u[20] ? t_neg[19:0] : t_red[19:0];

	// start pulses go out the cycle after a divide or multiply state is entered
	assign div_launch = launch_q && (state_q == ST_MECH || state_q == ST_MODF
		|| state_q == ST_ZONE || state_q == ST_PTDIV || state_q == ST_HTDIV
		|| state_q == ST_STEP);
	assign mul_launch = launch_q && (state_q == ST_PTMUL || state_q == ST_HTMUL);

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_q      <= 18'sd5000;
			pole_count_q    <= 7'd12;
			drive_enable_q  <= 1'b1;
			power_percent_q <= 7'd50;
			pwm_period_q    <= 16'd8000;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_VELOCITY:      velocity_q      <= cfg_data;
				REG_POLE_COUNT:    pole_count_q    <= cfg_data[6:0];
				REG_DRIVE_ENABLE:  drive_enable_q  <= cfg_data[0];
				REG_POWER_PERCENT: power_percent_q <= cfg_data[6:0];
				REG_PWM_PERIOD:    pwm_period_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			drive_q     <= 1'b0;
			step_neg_q  <= 1'b0;
			step_mag_q  <= '0;
			sum_q       <= '0;
			angle_q     <= '0;
			mech_q      <= '0;
			afold_q     <= '0;
			zone_q      <= '0;
			pos_q       <= '0;
			zp_q        <= '0;
			prod_q      <= '0;
			pt_q        <= '0;
			ht_q        <= '0;
			t_q         <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			div_req_q   <= '0;
			mul_req_q   <= '0;
		end else begin
			div_req_q.start <= div_launch;
			mul_req_q.start <= mul_launch;
			// the output state handles a drain that coincides with a new load
			if (res_valid_q && !res_stall && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						launch_q <= 1'b1;
						if (cmd.op == OP_STEP) begin
							step_neg_q <= step_raw[15];
							step_mag_q <= step_abs;
							state_q    <= ST_STEP;
						end else if (!drive_enable_q) begin
							drive_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							drive_q <= 1'b1;
							sum_q   <= 21'(angle_q) + 21'(velocity_q);
							state_q <= ST_MECH;
						end
					end
				end

				ST_MECH: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= DVD_W'(sum_mag) << (DVD_W - SUM_MAG_W);
						div_req_q.divisor  <= DSR_W'(poles);
						div_req_q.steps    <= CNT_W'(SUM_MAG_W);
					end else if (div_rsp.done) begin
						mech_q   <= mech_sat;
						launch_q <= 1'b1;
						state_q  <= ST_MODF;
					end
				end

				ST_MODF: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= DVD_W'(sum_mag) << (DVD_W - SUM_MAG_W);
						div_req_q.divisor  <= FULL_D;
						div_req_q.steps    <= CNT_W'(SUM_MAG_W);
					end else if (div_rsp.done) begin
						angle_q  <= sum_u[20] ? (~rem20 + 20'd1) : rem20;
						// negative remainders fold up by one full turn
						afold_q  <= (sum_u[20] && div_rsp.remainder != '0)
							? (FULL_D - div_rsp.remainder) : div_rsp.remainder;
						launch_q <= 1'b1;
						state_q  <= ST_ZONE;
					end
				end

				ST_ZONE: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= DVD_W'(afold_q) << (DVD_W - FOLD_W);
						div_req_q.divisor  <= SECTOR_D;
						div_req_q.steps    <= CNT_W'(FOLD_W);
					end else if (div_rsp.done) begin
						// a turn that is not a multiple of six leaves a tail in the last zone
						zone_q   <= zone_over ? 3'd5 : div_rsp.quotient[2:0];
						pos_q    <= zone_over ? POS_W'(afold_q - LAST_BASE)
							: POS_W'(div_rsp.remainder);
						launch_q <= 1'b1;
						state_q  <= ST_PTMUL;
					end
				end

				ST_PTMUL: begin
					if (launch_q) begin
						launch_q    <= 1'b0;
						zp_q        <= zp_calc;
						mul_req_q.a <= zp_calc;
						mul_req_q.b <= pwm_period_q;
					end else if (mul_rsp.done) begin
						prod_q   <= mul_rsp.product;
						launch_q <= 1'b1;
						state_q  <= ST_PTDIV;
					end
				end

				ST_PTDIV: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= DVD_W'(prod_q) << (DVD_W - PT_DVD_W);
						div_req_q.divisor  <= SECTOR_D;
						div_req_q.steps    <= CNT_W'(PT_DVD_W);
					end else if (div_rsp.done) begin
						pt_q     <= quo_sat16;
						launch_q <= 1'b1;
						state_q  <= ST_HTMUL;
					end
				end

				ST_HTMUL: begin
					if (launch_q) begin
						launch_q    <= 1'b0;
						mul_req_q.a <= MUL_A_W'(pwm_period_q);
						mul_req_q.b <= MUL_B_W'(power_percent_q);
					end else if (mul_rsp.done) begin
						prod_q   <= mul_rsp.product;
						launch_q <= 1'b1;
						state_q  <= ST_HTDIV;
					end
				end

				ST_HTDIV: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= {prod_q[HT_DVD_W-1:0], {(DVD_W-HT_DVD_W){1'b0}}};
						div_req_q.divisor  <= PERCENT_DIV;
						div_req_q.steps    <= CNT_W'(HT_DVD_W);
					end else if (div_rsp.done) begin
						ht_q    <= quo_sat16;
						state_q <= ST_OUT;
					end
				end

				ST_STEP: begin
					if (launch_q) begin
						launch_q           <= 1'b0;
						div_req_q.dividend <= {step_x1000[STEP_W-1:0], {(DVD_W-STEP_W){1'b0}}};
						div_req_q.divisor  <= FULL_D;
						div_req_q.steps    <= CNT_W'(STEP_W);
					end else if (div_rsp.done) begin
						t_q     <= 21'(angle_q) + (step_neg_q ? -rem21 : rem21);
						state_q <= ST_WRAP;
					end
				end

				ST_WRAP: begin
					angle_q <= wrap_angle;
					state_q <= ST_IDLE;
				end

				ST_OUT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						if (drive_q) begin
							res_q.drive_on    <= 1'b1;
							res_q.zone        <= zone_q;
							res_q.high_phase  <= high_phase_of(zone_q);
							res_q.low_phase   <= low_phase_of(zone_q);
							res_q.pwm_phase   <= pwm_phase_of(zone_q);
							res_q.sector_ramp <= 18'(zp_q);
							res_q.pwm_on      <= pt_q;
							res_q.high_time   <= ht_q;
							res_q.rotor_pos   <= mech_q;
						end else begin
							res_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---- assertions ----
	a_angle_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_q < FULL) && (angle_q > -FULL))
		else $error("electrical angle left the open full-turn range");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_MECH || state_q == ST_MODF || state_q == ST_ZONE
			|| state_q == ST_PTDIV || state_q == ST_HTDIV || state_q == ST_STEP))
		else $error("divider finished outside a divide state");

	a_mul_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_PTMUL || state_q == ST_HTMUL))
		else $error("multiplier finished outside a multiply state");

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result loaded without passing the output state");

	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && drive_q) |-> (zone_q <= 3'd5 && zp_q <= ZP_W'(SECTOR / 2 + 3)))
		else $error("zone or zone phase out of range at result load");

endmodule

>>> tb/sv/commutation_checker.sv
`timescale 1ns / 100ps
// Commutation checker: mirrors the core's registers and electrical angle and predicts
// one result per tick. Every res transfer is compared with the oldest prediction.
// Depends on ssc_pkg (cmd_t, res_t, op codes, register indexes, default full turn).
module commutation_checker import ssc_pkg::*; #(
	parameter int FULL_ANGLE = FULL_ANGLE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  cmd_t        cmd,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_t        res,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	output int          mismatches,
	output int          awaited,
	output int          compared
);

	localparam longint TURN   = FULL_ANGLE < MIN_FULL ? MIN_FULL : FULL_ANGLE;
	localparam longint SECTOR = TURN / 6;

	// phase per zone, zone 0 in the low bits
	localparam logic [11:0] HIGH_SIDE = {2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
	localparam logic [11:0] LOW_SIDE  = {2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
	localparam logic [11:0] PWM_SIDE  = {2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};

	logic signed [17:0] velocity_q;
	logic [6:0]         poles_q;
	logic               drive_q;
	logic [6:0]         power_q;
	logic [15:0]        period_q;
	longint             angle_q;

	res_t pending_results[$];
	res_t want;

	// advance the angle by one tick and work out the phase outputs when the drive is on; else zero result, angle held
	task automatic commutate(output res_t r);
		longint sum, divisor, mech, folded, zp, pt, ht;
		int     zone;
		r = '0;
		if (drive_q) begin
			sum     = angle_q + longint'(velocity_q);
			divisor = (poles_q == 7'd0) ? 64'sd1 : longint'(poles_q);
			mech    = sum / divisor;
			if (mech > 524287) mech = 524287;
			if (mech < -524288) mech = -524288;
			angle_q = sum % TURN;
			folded  = (angle_q < 0) ? angle_q + TURN : angle_q;
			zone    = int'(folded / SECTOR);
			if (zone > 5) zone = 5;
			zp = (folded - zone * SECTOR) / 2;
			// odd sectors run the triangle downward
			if (zone % 2 == 1) begin
				zp = SECTOR / 2 - zp;
				if (zp < 0) zp = 0;
			end
			pt = zp * longint'(period_q) / SECTOR;
			if (pt > 65535) pt = 65535;
			ht = longint'(period_q) * longint'(power_q) / 100;
			if (ht > 65535) ht = 65535;
			r.drive_on    = 1'b1;
			r.zone        = 3'(zone);
			r.high_phase  = HIGH_SIDE[2*zone +: 2];
			r.low_phase   = LOW_SIDE[2*zone +: 2];
			r.pwm_phase   = PWM_SIDE[2*zone +: 2];
			r.sector_ramp = 18'(zp);
			r.pwm_on      = 16'(pt);
			r.high_time   = 16'(ht);
			r.rotor_pos   = 20'(mech);
		end
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_q = 18'sd5000;
			poles_q    = 7'd12;
			drive_q    = 1'b1;
			power_q    = 7'd50;
			period_q   = 16'd8000;
			angle_q    = 0;
			pending_results.delete();
			mismatches = 0;
			awaited    = 0;
			compared   = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no tick outstanding, expected none, actual %h",
						$time, res);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("drive_on", want.drive_on, res.drive_on);
					check_field("zone", want.zone, res.zone);
					check_field("high_phase", want.high_phase, res.high_phase);
					check_field("low_phase", want.low_phase, res.low_phase);
					check_field("pwm_phase", want.pwm_phase, res.pwm_phase);
					check_field("sector_ramp", want.sector_ramp, res.sector_ramp);
					check_field("pwm_on", want.pwm_on, res.pwm_on);
					check_field("high_time", want.high_time, res.high_time);
					check_field("rotor_pos", want.rotor_pos, res.rotor_pos);
					compared++;
				end
			end
			if (cfg_wen) begin
				case (cfg_index)
					REG_VELOCITY:      velocity_q = cfg_data;
					REG_POLE_COUNT:    poles_q    = cfg_data[6:0];
					REG_DRIVE_ENABLE:  drive_q    = cfg_data[0];
					REG_POWER_PERCENT: power_q    = cfg_data[6:0];
					REG_PWM_PERIOD:    period_q   = cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd.op == OP_STEP) begin
					angle_q = (angle_q + (longint'(cmd.angle_step) * 1000) % TURN) % TURN;
				end else if (cmd.op == OP_TICK) begin
					commutate(want);
					pending_results.push_back(want);
				end
			end
			awaited = pending_results.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the commutation core testbench: clock, reset, command and register stimulus,
// random idling on both channels and the verdict. Depends on ssc_pkg, the core and
// commutation_checker.
module testbench import ssc_pkg::*; ();

	localparam int   SETTLE_CYCLES = 40;	// covers a step, which gives no result
	localparam int   RANDOM_PHASES = 15;
	localparam int   PHASE_ITEMS   = 50;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;

	int mismatches, awaited, compared;
	int sent, settings;
	bit idle_on;

	six_step_commutation_angle_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	commutation_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaited    (awaited),
		.compared   (compared)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAIL six_step_commutation_angle_core");
		$finish;
	end

	// receiver stalls in short bursts
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// present one command and hold it until the transfer
	task automatic send_item(input logic op, input logic [15:0] step);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		cmd_valid       <= 1'b1;
		cmd.op          <= op;
		cmd.angle_step  <= step;
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	// drop valid, wait for every result and let a trailing step finish
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		settings++;
	endtask

	task automatic random_settings();
		logic [17:0] vel;
		logic [15:0] per;
		case ($urandom_range(0, 5))
			0: vel = 18'h20000;
			1: vel = 18'h1FFFF;
			2: vel = 18'($urandom_range(0, 20000));
			default: vel = 18'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: per = 16'd0;
			1: per = 16'd1;
			2: per = 16'hFFFF;
			default: per = 16'($urandom);
		endcase
		write_reg(REG_VELOCITY, vel);
		write_reg(REG_POLE_COUNT, 18'($urandom_range(0, 127)));
		write_reg(REG_DRIVE_ENABLE, 18'($urandom_range(0, 5) != 0));
		write_reg(REG_POWER_PERCENT, ($urandom_range(0, 3) == 0) ?
			18'($urandom_range(0, 127)) : 18'($urandom_range(0, 100)));
		write_reg(REG_PWM_PERIOD, per);
	endtask

	initial begin
		idle_on   = 1'b1;
		sent      = 0;
		settings  = 0;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_wen   = 1'b0;
		cfg_index = REG_VELOCITY;
		cfg_data  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset defaults, step extremes
		send_item(OP_TICK, 16'h0000);
		send_item(OP_STEP, 16'h7FFF);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_STEP, 16'h8000);
		send_item(OP_TICK, 16'hFFFF);
		send_item(OP_STEP, 16'h0000);
		send_item(OP_TICK, 16'h0000);
		settle();

		// most negative velocity: negative angles fold; zero poles; high time saturates
		write_reg(REG_VELOCITY, 18'h20000);
		write_reg(REG_POLE_COUNT, 18'd0);
		write_reg(REG_POWER_PERCENT, 18'd127);
		write_reg(REG_PWM_PERIOD, 18'hFFFF);
		repeat (3) send_item(OP_TICK, 16'h0000);
		send_item(OP_STEP, 16'hFFFF);
		send_item(OP_TICK, 16'h0000);
		settle();

		// most positive velocity, widest pole field, zero power and period
		write_reg(REG_VELOCITY, 18'h1FFFF);
		write_reg(REG_POLE_COUNT, 18'd127);
		write_reg(REG_POWER_PERCENT, 18'd0);
		write_reg(REG_PWM_PERIOD, 18'd0);
		repeat (2) send_item(OP_TICK, 16'h0000);
		settle();

		// drive off: zero result, angle held, steps still move it
		write_reg(REG_DRIVE_ENABLE, 18'd0);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_STEP, 16'd5);
		send_item(OP_TICK, 16'h0000);
		settle();
		write_reg(REG_DRIVE_ENABLE, 18'd1);
		send_item(OP_TICK, 16'h0000);
		settle();

		// one sector per tick walks all six zones
		write_reg(REG_VELOCITY, 18'd60000);
		write_reg(REG_POLE_COUNT, 18'd64);
		write_reg(REG_POWER_PERCENT, 18'd100);
		write_reg(REG_PWM_PERIOD, 18'd1);
		repeat (6) send_item(OP_TICK, 16'h0000);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p >= RANDOM_PHASES - 2) idle_on = 1'b0;
			random_settings();
			repeat (PHASE_ITEMS)
				send_item(($urandom_range(0, 4) == 0) ? OP_STEP : OP_TICK, 16'($urandom));
			settle();
		end

		$display("Run covered %0d commands under %0d register setups; %0d results compared.",
			sent, settings, compared);
		if (mismatches == 0) begin
			$display("PASS six_step_commutation_angle_core");
		end else begin
			$display("FAIL six_step_commutation_angle_core");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/ssc_pkg.sv
sv/ssc_div.sv
sv/ssc_mul.sv
sv/six_step_commutation_angle_core.sv
tb/sv/commutation_checker.sv
tb/sv/testbench.sv
